>>> rtl/gbnms_pkg.sv
// Package for the greedy box NMS unit: widths, constants, record types.
// Used by the top level and the IoU datapath; depends on nothing.
package gbnms_pkg;

    localparam int MAX_PROPOSALS = 128;
    localparam int IDX_W = $clog2(MAX_PROPOSALS);
    localparam int CNT_W = IDX_W + 1;
    localparam int BOX_W = 50;
    localparam int TAG_W = 20;

    localparam logic [1:0] CFG_SUP_THR = 2'd0;
    localparam logic [1:0] CFG_MRG_THR = 2'd1;
    localparam logic [1:0] CFG_MRG_TOL = 2'd2;

    typedef struct packed {
        logic signed [11:0] left;
        logic signed [11:0] top;
        logic [12:0] width;
        logic [12:0] height;
    } t_box;

    typedef struct packed {
        logic [6:0] index;
        logic [1:0] color;
        logic [2:0] cls;
        logic [7:0] score;
    } t_tag;

    typedef struct packed {
        logic [6:0] proposal_index;
        logic kept;
        logic [6:0] suppressor_index;
        logic merge;
        logic dropped;
    } t_result;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_OVL,
        ST_MUL,
        ST_CMP,
        ST_DONE
    } t_state;

endpackage

>>> rtl/greedy_box_nms_with_merge_unit.sv
// Greedy box NMS with merge reporting.
// A dropped proposal, or one that meets an empty kept list, goes straight to the result step;
// else the kept list is scanned until a box suppresses it. One proposal is in work at a time.
// Each kept box costs one memory read and three datapath steps; a waiting result only holds
// the final step, since the output register frees the input side.
// Synchronous active-low reset clears counters and control and sets the default thresholds;
// the kept-box memories are not cleared and are read only below the kept count.
module greedy_box_nms_with_merge_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [63:0] s_axis_tdata,   // box_left, box_top, box_width, box_height,
                                        // score, class_id, color_id
    input  logic        s_axis_tuser,   // frame_start
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata,   // proposal_index, kept, suppressor_index,
                                        // merge, dropped
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [8:0]  i_cfg_data
);
    import gbnms_pkg::*;

    t_state r_state, n_state;
    t_box r_prop;
    t_tag r_ptag;
    logic [CNT_W-1:0] r_kcnt, r_pcnt, r_scan;
    logic [8:0] r_sup, r_mrg;
    logic [7:0] r_tol;
    t_result r_res;
    t_result r_work;
    t_result work_init;
    logic r_out_v;
    logic [BOX_W-1:0] box_rd;
    logic [TAG_W-1:0] tag_rd;
    t_tag kt;
    t_tag r_kt;
    logic sup, mrg_iou, accept, we, last, drop_req, done_go;
    logic [7:0] diff;
    logic [CNT_W-1:0] kcnt_eff, pcnt_eff;

    assign accept = s_axis_tvalid && s_axis_tready;
    assign o_cfg_ready = 1'b1;
    assign kcnt_eff = s_axis_tuser ? '0 : r_kcnt;
    assign pcnt_eff = s_axis_tuser ? '0 : r_pcnt;
    assign drop_req = pcnt_eff >= CNT_W'(MAX_PROPOSALS);
    assign last = (r_scan + 1'b1) >= r_kcnt;
    assign kt = t_tag'(tag_rd);

    gbnms_ram #(.WIDTH(BOX_W), .DEPTH(MAX_PROPOSALS)) u_box_ram (
        .i_clk(i_clk), .i_we(we), .i_waddr(r_kcnt[IDX_W-1:0]), .i_wdata(r_prop),
        .i_raddr(r_scan[IDX_W-1:0]), .o_rdata(box_rd));
    gbnms_ram #(.WIDTH(TAG_W), .DEPTH(MAX_PROPOSALS)) u_tag_ram (
        .i_clk(i_clk), .i_we(we), .i_waddr(r_kcnt[IDX_W-1:0]), .i_wdata(r_ptag),
        .i_raddr(r_scan[IDX_W-1:0]), .o_rdata(tag_rd));

    gbnms_iou u_iou (
        .i_clk(i_clk), .i_prop(r_prop), .i_kept(t_box'(box_rd)),
        .i_sup_thr(r_sup), .i_mrg_thr(r_mrg),
        .o_suppress(sup), .o_merge_iou(mrg_iou));

    assign diff = (r_ptag.score > r_kt.score) ? r_ptag.score - r_kt.score
                                              : r_kt.score - r_ptag.score;

    // Starting verdict of an accepted request: either dropped or kept until suppressed.
    always_comb begin
        work_init = '0;
        if (drop_req) begin
            work_init.dropped = 1'b1;
        end else begin
            work_init.proposal_index = pcnt_eff[IDX_W-1:0];
            work_init.kept = 1'b1;
        end
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: if (accept) begin
                n_state = (drop_req || kcnt_eff == '0) ? ST_DONE : ST_READ;
            end
            ST_READ: n_state = ST_OVL;
            ST_OVL:  n_state = ST_MUL;
            ST_MUL:  n_state = ST_CMP;
            ST_CMP:  n_state = (sup || last) ? ST_DONE : ST_READ;
            ST_DONE: if (done_go) begin
                n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // State-machine outputs: input ready, result hand-over and kept-list write.
    always_comb begin
        s_axis_tready = (r_state == ST_IDLE);
        done_go = (r_state == ST_DONE) && (!r_out_v || m_axis_tready);
        we = done_go && r_work.kept && (r_kcnt < CNT_W'(MAX_PROPOSALS));
    end

    // Control and datapath registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_kcnt <= '0;
            r_pcnt <= '0;
            r_out_v <= 1'b0;
            r_sup <= 9'd77;
            r_mrg <= 9'd230;
            r_tol <= 8'd38;
        end else begin
            r_state <= n_state;
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    CFG_SUP_THR: r_sup <= i_cfg_data;
                    CFG_MRG_THR: r_mrg <= i_cfg_data;
                    CFG_MRG_TOL: r_tol <= i_cfg_data[7:0];
                    default: ;
                endcase
            end

            // Output register: loaded when the finished verdict can move in.
            if (done_go) begin
                r_out_v <= 1'b1;
                r_res <= r_work;
            end else if (m_axis_tvalid && m_axis_tready) begin
                r_out_v <= 1'b0;
            end

            // Frame counters; a dropped request leaves them alone.
            if (accept) begin
                r_kcnt <= kcnt_eff;
                r_pcnt <= pcnt_eff;
            end else if (done_go && !r_work.dropped) begin
                r_pcnt <= r_pcnt + 1'b1;
                if (we) r_kcnt <= r_kcnt + 1'b1;
            end

            // Scan position over the kept list.
            if (accept) begin
                r_scan <= '0;
            end else if (r_state == ST_CMP) begin
                r_scan <= r_scan + 1'b1;
            end

            if (accept) begin
                r_prop <= {s_axis_tdata[11:0], s_axis_tdata[23:12], s_axis_tdata[36:24],
                           s_axis_tdata[49:37]};
                r_ptag <= {pcnt_eff[6:0], s_axis_tdata[62:61], s_axis_tdata[60:58],
                           s_axis_tdata[57:50]};
            end

            // The tag read for the current scan position is valid from this state on.
            if (r_state == ST_OVL) r_kt <= kt;

            // Working verdict.
            if (accept) begin
                r_work <= work_init;
            end else if (r_state == ST_CMP && sup) begin
                r_work.kept <= 1'b0;
                r_work.suppressor_index <= r_kt.index;
                r_work.merge <= mrg_iou && (diff < r_tol) &&
                                (r_kt.cls == r_ptag.cls) && (r_kt.color == r_ptag.color);
            end
        end
    end

    assign m_axis_tvalid = r_out_v;
    assign m_axis_tdata = {7'd0, r_res.dropped, r_res.merge, r_res.suppressor_index,
                           r_res.kept, r_res.proposal_index};
endmodule

>>> rtl/gbnms_ram.sv
// Generic single-port-write, single-port-read RAM with registered read.
// No dependencies.
module gbnms_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port and registered read port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

>>> rtl/gbnms_iou.sv
// IoU datapath: overlap and area products in two register stages, then the threshold compares.
// Depends on gbnms_pkg.
module gbnms_iou (
    input  logic                i_clk,
    input  gbnms_pkg::t_box     i_prop,
    input  gbnms_pkg::t_box     i_kept,
    input  logic [8:0]          i_sup_thr,
    input  logic [8:0]          i_mrg_thr,
    output logic                o_suppress,
    output logic                o_merge_iou
);
    import gbnms_pkg::*;

    logic signed [14:0] x0, y0, x1, y1, ar, br, ab, bb;
    logic signed [15:0] dx, dy;
    logic [12:0] r_dx, r_dy, r_pw, r_ph, r_kw, r_kh;
    logic [25:0] r_inter, r_ap, r_ak;
    logic [27:0] uni;
    logic [51:0] lhs, rs, rm;

    // Stage 1: overlap extents. Right and bottom edges can reach 2047 + 8191.
    always_comb begin
        ar = 15'(i_prop.left) + $signed({2'b00, i_prop.width});
        br = 15'(i_kept.left) + $signed({2'b00, i_kept.width});
        ab = 15'(i_prop.top) + $signed({2'b00, i_prop.height});
        bb = 15'(i_kept.top) + $signed({2'b00, i_kept.height});
        x0 = (i_prop.left > i_kept.left) ? 15'(i_prop.left) : 15'(i_kept.left);
        y0 = (i_prop.top > i_kept.top) ? 15'(i_prop.top) : 15'(i_kept.top);
        x1 = (ar < br) ? ar : br;
        y1 = (ab < bb) ? ab : bb;
        dx = 16'(x1) - 16'(x0);
        dy = 16'(y1) - 16'(y0);
    end

    always_ff @(posedge i_clk) begin
        r_dx <= (dx > 0) ? dx[12:0] : '0;
        r_dy <= (dy > 0) ? dy[12:0] : '0;
        r_pw <= i_prop.width;
        r_ph <= i_prop.height;
        r_kw <= i_kept.width;
        r_kh <= i_kept.height;
    end

    // Stage 2: the three area products.
    always_ff @(posedge i_clk) begin
        r_inter <= r_dx * r_dy;
        r_ap    <= r_pw * r_ph;
        r_ak    <= r_kw * r_kh;
    end

    // Stage 3: union and scaled compares, seen by the controller in the same cycle.
    always_comb begin
        uni = 28'(r_ap) + 28'(r_ak) - 28'(r_inter);
        lhs = {18'd0, r_inter, 8'd0};
        rs  = 52'(i_sup_thr) * 52'(uni);
        rm  = 52'(i_mrg_thr) * 52'(uni);
        o_suppress  = (uni == '0) || (lhs > rs);
        o_merge_iou = (uni != '0) && (lhs > rm);
    end
endmodule

>>> rtl/gbnms_checker.sv
// Port-level checker for the NMS unit, bound to the top level.
// Depends only on the top level's ports.
module gbnms_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [23:0] m_axis_tdata
);
    // A stalled result holds.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result changed under stall");
    // A dropped result carries no other flags.
    a_drop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tdata[16] |-> m_axis_tdata[15:0] == 16'd0)
        else $error("drop with fields");
    // Merge only on suppressed proposals.
    a_mrg: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tdata[15] |-> !m_axis_tdata[7])
        else $error("merge on kept");
    // One request is in work at a time.
    a_one: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("input ready right after a request");
endmodule

bind greedy_box_nms_with_merge_unit gbnms_checker u_chk (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready), .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready), .m_axis_tdata(m_axis_tdata));
